/* hdl/tto_pkg.sv */
// Package: shared types and constants of the tangent orthonormalizer.
`timescale 1ns / 1ps
package tto_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NORM_W  = 16;
  localparam int VEC_W   = 64;   // working width of vectors to normalize
  localparam int MAG_W   = 25;   // normalized magnitude range, below 2^24
  localparam int SQ_W    = 52;   // sum of three squares of 25-bit values
  localparam int LEN_W   = 26;   // integer square root of SQ_W bits
  localparam int QUO_W   = 15;   // quotient, at most 16384
  localparam int SH_W    = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_NORM_N,
    ST_NORM_T,
    ST_DOT,
    ST_GS,
    ST_NORM_W,
    ST_OUT
  } tto_state_t;

  // Normalizer sequencer states.
  typedef enum logic [2:0] {
    N_IDLE, N_MAX, N_SCALE, N_SQ, N_ROOT, N_DIV, N_DONE
  } tto_norm_state_t;

  // Normalizer operand select.
  typedef enum logic [1:0] {
    SRC_NORMAL,
    SRC_RAW,
    SRC_GS
  } tto_src_t;

  typedef struct packed {
    logic     capture;    // take an accepted vertex
    logic     calc_raw;   // form raw tangent from held data
    logic     norm_start;
    tto_src_t norm_src;
    logic     save_n;
    logic     save_t;
    logic     calc_dot;
    logic     calc_gs;
    logic     save_f;
    logic     clear_bad;
  } tto_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic norm_ok;
  } tto_sts_t;

endpackage

/* hdl/tto_norm.sv */
// Iterative fixed-point vector normalizer: scale, square sum, root, three divides.
`timescale 1ns / 1ps
module tto_norm import tto_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  input  logic signed [VEC_W-1:0] vec_z,
  output logic                    done,
  output logic                    ok,
  output logic signed [NORM_W-1:0] res_x,
  output logic signed [NORM_W-1:0] res_y,
  output logic signed [NORM_W-1:0] res_z
);

  tto_norm_state_t state_r, state_nxt;

  logic signed [VEC_W-1:0] v_r [3];
  logic [VEC_W-1:0] a_r [3];
  logic [VEC_W-1:0] m_r;
  logic [MAG_W-1:0] c_r [3];     // magnitudes after scaling
  logic             neg_r [3];
  logic [SQ_W-1:0]  sq_r;
  logic [1:0]       idx_r;       // element index for squares and divides
  logic [SQ_W-1:0]  rem_r;
  logic [SQ_W-1:0]  root_r;      // wide while iterating, final root fits LEN_W
  logic [4:0]       rstep_r;     // root digit counter
  logic [QUO_W+LEN_W-1:0] drem_r;
  logic [QUO_W-1:0] quo_r;
  logic [4:0]       dstep_r;
  logic signed [NORM_W-1:0] o_r [3];
  logic             ok_r;

  // scale: shift count from the highest set bit of the max magnitude
  logic [SH_W-1:0] rsh, lsh;
  always_comb begin
    rsh = '0;
    lsh = '0;
    for (int b = 24; b < VEC_W; b++)
      if (m_r[b]) rsh = SH_W'(b - 23);
    for (int b = 0; b < 24; b++)
      if (m_r[b]) lsh = SH_W'(23 - b);
  end

  logic signed [VEC_W-1:0] scaled [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      scaled[i] = (rsh != '0) ? (v_r[i] >>> rsh) : (v_r[i] <<< lsh);
  end

  logic [2*MAG_W-1:0] c_sq;
  assign c_sq = c_r[idx_r] * c_r[idx_r];

  // root step: restoring, two bits a step
  logic [SQ_W-1:0]  r_bit;
  logic [SQ_W+1:0]  r_trial;
  logic [SQ_W-1:0]  root_nxt;
  assign r_bit    = SQ_W'(1) << (2 * (LEN_W - 1 - int'(rstep_r)));
  assign r_trial  = {2'b0, root_r} + {2'b0, r_bit};
  assign root_nxt = ({2'b0, rem_r} >= r_trial) ? (root_r >> 1) + r_bit : (root_r >> 1);

  // divide step: restoring, one quotient bit a step
  logic [QUO_W+LEN_W-1:0] d_sub;
  assign d_sub = (QUO_W+LEN_W)'(root_r) << (QUO_W - 1 - int'(dstep_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE:  if (start) state_nxt = N_MAX;
      N_MAX:   state_nxt = N_SCALE;
      N_SCALE: state_nxt = (m_r == '0) ? N_DONE : N_SQ;
      N_SQ:    if (idx_r == 2'd2) state_nxt = N_ROOT;
      N_ROOT:  if (rstep_r == 5'(LEN_W - 1)) state_nxt = N_DIV;
      N_DIV:   if (dstep_r == 5'(QUO_W - 1) && idx_r == 2'd2) state_nxt = N_DONE;
      N_DONE:  state_nxt = start ? N_MAX : N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= N_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      N_IDLE, N_DONE: if (start) begin
        v_r[0] <= vec_x; v_r[1] <= vec_y; v_r[2] <= vec_z;
        a_r[0] <= vec_x[VEC_W-1] ? VEC_W'(-vec_x) : VEC_W'(vec_x);
        a_r[1] <= vec_y[VEC_W-1] ? VEC_W'(-vec_y) : VEC_W'(vec_y);
        a_r[2] <= vec_z[VEC_W-1] ? VEC_W'(-vec_z) : VEC_W'(vec_z);
      end
      N_MAX: begin
        m_r <= (a_r[0] > a_r[1]) ? ((a_r[0] > a_r[2]) ? a_r[0] : a_r[2])
                                 : ((a_r[1] > a_r[2]) ? a_r[1] : a_r[2]);
      end
      N_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= scaled[i][VEC_W-1];
          c_r[i]   <= scaled[i][VEC_W-1] ? MAG_W'(-scaled[i]) : MAG_W'(scaled[i]);
        end
        sq_r  <= '0;
        idx_r <= '0;
        ok_r  <= (m_r != '0);
        for (int i = 0; i < 3; i++) o_r[i] <= '0;
      end
      N_SQ: begin
        sq_r  <= sq_r + SQ_W'(c_sq);
        if (idx_r == 2'd2) begin
          rem_r   <= sq_r + SQ_W'(c_sq);
          root_r  <= '0;
          rstep_r <= '0;
        end
        idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
      end
      N_ROOT: begin
        // root_r holds r scaled by bit as in the classic digit-by-digit form
        if ({2'b0, rem_r} >= r_trial) rem_r <= rem_r - SQ_W'(r_trial);
        root_r  <= root_nxt;
        rstep_r <= rstep_r + 5'd1;
        if (rstep_r == 5'(LEN_W - 1)) begin
          drem_r  <= (QUO_W+LEN_W)'({c_r[0], 14'd0}) + (QUO_W+LEN_W)'(root_nxt >> 1);
          quo_r   <= '0;
          dstep_r <= '0;
          idx_r   <= '0;
        end
      end
      N_DIV: begin
        if (dstep_r == 5'(QUO_W - 1)) begin
          o_r[idx_r] <= neg_r[idx_r] ? -NORM_W'(quo_r | QUO_W'(drem_r >= d_sub))
                                     :  NORM_W'(quo_r | QUO_W'(drem_r >= d_sub));
          dstep_r <= '0;
          quo_r   <= '0;
          if (idx_r != 2'd2) begin
            drem_r <= (QUO_W+LEN_W)'({c_r[idx_r+2'd1], 14'd0}) +
                      (QUO_W+LEN_W)'(root_r >> 1);
            idx_r  <= idx_r + 2'd1;
          end
        end else begin
          if (drem_r >= d_sub) begin
            drem_r <= drem_r - d_sub;
            quo_r  <= quo_r | (QUO_W'(1) << (QUO_W - 1 - int'(dstep_r)));
          end
          dstep_r <= dstep_r + 5'd1;
        end
      end
      default: ;
    endcase
  end

  assign done  = (state_r == N_DONE);
  assign ok    = ok_r;
  assign res_x = o_r[0];
  assign res_y = o_r[1];
  assign res_z = o_r[2];

endmodule

/* hdl/tto_datapath.sv */
// Datapath: vertex holding registers, raw tangent, Gram-Schmidt and result register.
`timescale 1ns / 1ps
module tto_datapath import tto_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tto_cmd_t                      cmd,
  output tto_sts_t                      sts,
  input  logic [1:0]                    phase,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_tex_v,
  input  logic signed [NORM_W-1:0]      in_norm_x,
  input  logic signed [NORM_W-1:0]      in_norm_y,
  input  logic signed [NORM_W-1:0]      in_norm_z,
  output logic signed [NORM_W-1:0]      tan_x,
  output logic signed [NORM_W-1:0]      tan_y,
  output logic signed [NORM_W-1:0]      tan_z,
  output logic                          degenerate
);

  localparam int PRE = (COORD_WIDTH > 24) ? COORD_WIDTH - 24 : 0;
  localparam int DW  = COORD_WIDTH + 1 - PRE;
  localparam int DOT_W = 2 * NORM_W + 2;   // sum of three Q2.28 products

  logic signed [COORD_WIDTH-1:0] pos_r [6];
  logic signed [COORD_WIDTH-1:0] tv_r [2];
  logic signed [COORD_WIDTH-1:0] p2_r [3];
  logic signed [COORD_WIDTH-1:0] v2_r;
  logic signed [NORM_W-1:0]      n0_r [3];
  logic signed [VEC_W-1:0]       vec_r [3];
  logic signed [NORM_W-1:0]      n_r [3], t_r [3];
  logic signed [DOT_W-1:0]       d_r;
  logic                          bad_r;
  logic signed [NORM_W-1:0]      f_r [3];
  logic [1:0]                    k_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (phase == 2'd0) begin
        pos_r[0] <= in_pos_x; pos_r[1] <= in_pos_y; pos_r[2] <= in_pos_z;
        tv_r[0]  <= in_tex_v;
        n0_r[0]  <= in_norm_x; n0_r[1] <= in_norm_y; n0_r[2] <= in_norm_z;
      end else if (phase == 2'd1) begin
        pos_r[3] <= in_pos_x; pos_r[4] <= in_pos_y; pos_r[5] <= in_pos_z;
        tv_r[1]  <= in_tex_v;
      end else begin
        p2_r[0] <= in_pos_x; p2_r[1] <= in_pos_y; p2_r[2] <= in_pos_z;
        v2_r    <= in_tex_v;
      end
    end
  end

  // Raw tangent, one component a cycle on one pair of multipliers.
  logic signed [DW-1:0] e1, e2, dv1, dv2;
  logic signed [COORD_WIDTH:0] e1w, e2w, dv1w, dv2w;
  always_comb begin
    e1w  = (COORD_WIDTH+1)'(pos_r[3'(k_r) + 3'd3]) - (COORD_WIDTH+1)'(pos_r[3'(k_r)]);
    e2w  = (COORD_WIDTH+1)'(p2_r[k_r]) - (COORD_WIDTH+1)'(pos_r[3'(k_r)]);
    dv1w = (COORD_WIDTH+1)'(tv_r[1]) - (COORD_WIDTH+1)'(tv_r[0]);
    dv2w = (COORD_WIDTH+1)'(v2_r) - (COORD_WIDTH+1)'(tv_r[0]);
    e1  = DW'(e1w >>> PRE);
    e2  = DW'(e2w >>> PRE);
    dv1 = DW'(dv1w >>> PRE);
    dv2 = DW'(dv2w >>> PRE);
  end

  logic signed [2*DW-1:0] pa, pb;
  assign pa = dv2 * e1;
  assign pb = dv1 * e2;

  // Dot product and Gram-Schmidt, one component a cycle.
  logic signed [2*NORM_W-1:0] tn;
  assign tn = t_r[k_r] * n_r[k_r];
  logic signed [DOT_W+NORM_W-1:0] dn;
  assign dn = d_r * n_r[k_r];

  logic signed [NORM_W-1:0] nr_x, nr_y, nr_z;
  logic nr_done, nr_ok;
  logic signed [VEC_W-1:0] src [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      src[i] = (cmd.norm_src == SRC_NORMAL) ? VEC_W'(n0_r[i]) : vec_r[i];
  end

  tto_norm u_norm (
    .clk, .rst_n,
    .start (cmd.norm_start),
    .vec_x (src[0]), .vec_y (src[1]), .vec_z (src[2]),
    .done  (nr_done), .ok (nr_ok),
    .res_x (nr_x), .res_y (nr_y), .res_z (nr_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.calc_raw || cmd.calc_dot || cmd.calc_gs) begin
      k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_bad) begin
      bad_r <= 1'b0;
      d_r   <= '0;
    end
    if (cmd.calc_raw) vec_r[k_r] <= VEC_W'(pa) - VEC_W'(pb);
    if (cmd.save_n) begin
      n_r[0] <= nr_x; n_r[1] <= nr_y; n_r[2] <= nr_z;
      if (!nr_ok) bad_r <= 1'b1;
    end
    if (cmd.save_t) begin
      t_r[0] <= nr_x; t_r[1] <= nr_y; t_r[2] <= nr_z;
      if (!nr_ok) bad_r <= 1'b1;
    end
    if (cmd.calc_dot) d_r <= d_r + DOT_W'(tn);
    if (cmd.calc_gs) vec_r[k_r] <= (VEC_W'(t_r[k_r]) <<< 28) - VEC_W'(dn);
    if (cmd.save_f) begin
      if (bad_r || !nr_ok) begin
        f_r[0] <= '0; f_r[1] <= '0; f_r[2] <= '0;
        degenerate <= 1'b1;
      end else begin
        f_r[0] <= nr_x; f_r[1] <= nr_y; f_r[2] <= nr_z;
        degenerate <= 1'b0;
      end
    end
  end

  assign sts.norm_done = nr_done;
  assign sts.norm_ok   = nr_ok;
  assign tan_x = f_r[0];
  assign tan_y = f_r[1];
  assign tan_z = f_r[2];

endmodule

/* hdl/tto_ctrl.sv */
// Controller: vertex phase, triangle sequencing and output handshake.
`timescale 1ns / 1ps
module tto_ctrl import tto_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  tto_sts_t   sts,
  output tto_cmd_t   cmd,
  output logic [1:0] phase
);

  tto_state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign phase    = phase_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        if (phase_r == 2'd2) begin
          phase_nxt = 2'd0;
          state_nxt = ST_RAW;
          cnt_nxt   = '0;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      ST_RAW: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          state_nxt = ST_NORM_N;
          cnt_nxt   = '0;
        end
      end
      ST_NORM_N: if (sts.norm_done) state_nxt = ST_NORM_T;
      ST_NORM_T: if (sts.norm_done) state_nxt = ST_DOT;
      ST_DOT: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          state_nxt = ST_GS;
          cnt_nxt   = '0;
        end
      end
      ST_GS: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_NORM_W;
          cnt_nxt   = '0;
        end
      end
      ST_NORM_W: if (sts.norm_done) state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.norm_src = SRC_NORMAL;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture   = acc;
        cmd.clear_bad = acc && (phase_r == 2'd2);
      end
      ST_RAW: begin
        cmd.calc_raw   = 1'b1;
        cmd.norm_start = (cnt_r == 2'd2);
      end
      ST_NORM_N: begin
        // normal is already captured; the restart takes the raw tangent
        cmd.norm_src   = SRC_RAW;
        cmd.save_n     = sts.norm_done;
        cmd.norm_start = sts.norm_done;
      end
      ST_NORM_T: begin
        cmd.norm_src = SRC_RAW;
        cmd.save_t   = sts.norm_done;
      end
      ST_DOT:    cmd.calc_dot = 1'b1;
      ST_GS: begin
        // update the three components, then start once the last component is stored
        cmd.calc_gs    = (cnt_r != 2'd3);
        cmd.norm_start = (cnt_r == 2'd3);
        cmd.norm_src   = SRC_GS;
      end
      ST_NORM_W: begin
        cmd.norm_src = SRC_GS;
        cmd.save_f   = sts.norm_done;
      end
      ST_OUT:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid = (state_r == ST_OUT);

endmodule

/* hdl/triangle_tangent_orthonormalizer.sv */
// Top level: per-triangle tangent with one Gram-Schmidt step, Q1.14 output.
// Sequence: the first two vertices of a triangle are only captured; the third
//   starts the run: raw tangent; normalizer runs (26 root steps, three 15-step
//   divides) on the normal and the raw tangent; dot product; Gram-Schmidt update;
//   a third normalizer run on its result; output. A zero-length vector ends its run
//   after scaling. Input stalls from the third vertex until the output is taken.
// Reset: synchronous, active low; clears the vertex phase and the sequencers.
`timescale 1ns / 1ps
module triangle_tangent_orthonormalizer import tto_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_tex_u,
  input  logic signed [COORD_WIDTH-1:0] in_tex_v,
  input  logic signed [NORM_W-1:0]      in_norm_x,
  input  logic signed [NORM_W-1:0]      in_norm_y,
  input  logic signed [NORM_W-1:0]      in_norm_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORM_W-1:0]      out_tan_x,
  output logic signed [NORM_W-1:0]      out_tan_y,
  output logic signed [NORM_W-1:0]      out_tan_z,
  output logic                          out_degenerate
);

  tto_cmd_t   cmd;
  tto_sts_t   sts;
  logic [1:0] phase;
  logic       unused_u;

  // tex_u does not enter the tangent; only v deltas do.
  assign unused_u = ^in_tex_u;

  tto_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid, .in_stall,
    .out_valid, .out_stall,
    .sts, .cmd, .phase
  );

  tto_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts, .phase,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_tex_v,
    .in_norm_x, .in_norm_y, .in_norm_z,
    .tan_x (out_tan_x), .tan_y (out_tan_y), .tan_z (out_tan_z),
    .degenerate (out_degenerate)
  );

endmodule
